>>> src/rfzp_pkg.sv
// Shared types and constants of the row-wise zero-padded FIR filter.
package rfzp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = 40;
    localparam int FRAC_BITS  = 14;
    localparam int OUT_W      = 24;
    localparam int TAP_CNT_W  = 5;
    localparam int ROW_LEN_W  = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int COEF_SLOTS = 16;
    localparam int TAP_IDX_W  = 4;
    localparam int LANE_IDX_W = 4;
    localparam int LANE_GROUP = 4;
    localparam int JQ_DEPTH   = 4;
    localparam int OQ_DEPTH   = 8;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(2 ** (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] OUT_MAX    = ACC_W'(2 ** (OUT_W - 1) - 1);
    localparam logic signed [ACC_W-1:0] OUT_MIN    = -ACC_W'(2 ** (OUT_W - 1));

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_COEF   = 1'b1
    } command_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAP_COUNT  = 1'b0,
        CFG_ROW_LENGTH = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        JOB_FILTER = 1'b0,
        JOB_COEF   = 1'b1
    } job_kind_t;

    typedef struct packed {
        command_t                    command;
        logic signed [SAMPLE_W-1:0]  sample;
        logic [TAP_IDX_W-1:0]        tap_index;
        logic signed [COEF_W-1:0]    tap_value;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered;
        logic                    row_end;
        logic                    run_last;
    } out_item_t;

    // Control part of one job; the sample window travels beside it.
    typedef struct packed {
        job_kind_t                kind;
        logic [TAP_IDX_W-1:0]     tap_index;
        logic signed [COEF_W-1:0] tap_value;
        logic [LANE_IDX_W-1:0]    d_first;
        logic                     row_last;
    } job_head_t;

    typedef struct packed {
        logic row_end;
        logic run_last;
    } res_flags_t;

endpackage

>>> src/rfzp_fifo.sv
// Small register-based first-in first-out queue.
module rfzp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> src/rfzp_front.sv
// Front end: configuration registers, row tracking, sample window and job building.
module rfzp_front
    import rfzp_pkg::*;
#(
    parameter int LANES   = 16,
    parameter int MAX_ROW = 4096,
    parameter int JOB_W   = $bits(job_head_t) + LANES * SAMPLE_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    input  in_item_t              item,
    input  logic                  job_full,
    output logic                  job_push,
    output logic [JOB_W-1:0]      job_data,
    output logic [TAP_CNT_W-1:0]  taps
);

    localparam int CW = $clog2(MAX_ROW);
    localparam int MW = $clog2(MAX_ROW + 1);
    localparam int LW = (MW > ROW_LEN_W) ? MW : ROW_LEN_W;
    localparam int PW = CW + LANE_IDX_W;

    logic [TAP_CNT_W-1:0]       tap_count_reg;
    logic [ROW_LEN_W-1:0]       row_length_reg;
    logic [CW-1:0]              col_reg, col_next;
    logic signed [SAMPLE_W-1:0] win_reg  [LANES];
    logic signed [SAMPLE_W-1:0] win_next [LANES];

    logic                  accept, is_sample;
    logic [LW-1:0]         len_ext, m_use;
    logic [CW-1:0]         col_eff;
    logic                  row_start, row_last, emit;
    logic [TAP_CNT_W-1:0]  ahead_wide;
    logic [LANE_IDX_W-1:0] ahead;
    logic [PW-1:0]         p_ext, ahead_ext;
    job_head_t             head;
    logic [LANES*SAMPLE_W-1:0] win_flat;

    assign accept    = push && !job_full;
    assign is_sample = (item.command == CMD_SAMPLE);

    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps = TAP_CNT_W'(1);
        end
        else if (tap_count_reg > TAP_CNT_W'(LANES))
        begin
            taps = TAP_CNT_W'(LANES);
        end
        else
        begin
            taps = tap_count_reg;
        end
    end

    always_comb
    begin
        len_ext = LW'(row_length_reg);
        if (len_ext == '0)
        begin
            m_use = LW'(1);
        end
        else if (len_ext > LW'(MAX_ROW))
        begin
            m_use = LW'(MAX_ROW);
        end
        else
        begin
            m_use = len_ext;
        end
    end

    // A position left past the end by a shorter row length restarts the row.
    assign col_eff    = (LW'(col_reg) >= m_use) ? '0 : col_reg;
    assign row_start  = (col_eff == '0);
    assign row_last   = (LW'(col_eff) == m_use - 1'b1);
    assign ahead_wide = taps - 1'b1 - (taps >> 1);
    assign ahead      = LANE_IDX_W'(ahead_wide);
    assign p_ext      = PW'(col_eff);
    assign ahead_ext  = PW'(ahead);
    assign emit       = row_last || (p_ext >= ahead_ext);
    assign col_next   = row_last ? '0 : col_eff + 1'b1;

    always_comb
    begin
        win_next[0] = item.sample;
        for (int i = 1; i < LANES; i++)
        begin
            win_next[i] = row_start ? '0 : win_reg[i-1];
        end
        for (int i = 0; i < LANES; i++)
        begin
            win_flat[i*SAMPLE_W +: SAMPLE_W] = win_next[i];
        end
    end

    always_comb
    begin
        head.kind      = is_sample ? JOB_FILTER : JOB_COEF;
        head.tap_index = item.tap_index;
        head.tap_value = item.tap_value;
        head.row_last  = row_last;
        if (row_last && (p_ext < ahead_ext))
        begin
            head.d_first = LANE_IDX_W'(p_ext);
        end
        else
        begin
            head.d_first = ahead;
        end
    end

    assign job_data = {head, win_flat};
    assign job_push = accept && (!is_sample || emit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg  <= TAP_CNT_W'(1);
            row_length_reg <= ROW_LEN_W'(4096);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_TAP_COUNT)
            begin
                tap_count_reg <= cfg_data[TAP_CNT_W-1:0];
            end
            else
            begin
                row_length_reg <= cfg_data[ROW_LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            for (int i = 0; i < LANES; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (accept && is_sample)
        begin
            col_reg <= col_next;
            for (int i = 0; i < LANES; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    a_row_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_sample && row_last) |=> (col_reg == '0))
        else $error("column did not return to zero after the last sample of a row");

endmodule

>>> src/rfzp_back.sv
// Back end: coefficient store, result sequencer and pipelined multiply-accumulate.
module rfzp_back
    import rfzp_pkg::*;
#(
    parameter int LANES = 16,
    parameter int JOB_W = $bits(job_head_t) + LANES * SAMPLE_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [TAP_CNT_W-1:0] taps,
    input  logic                 job_empty,
    input  logic [JOB_W-1:0]     job_data,
    output logic                 job_pop,
    output logic                 res_push,
    output out_item_t            res_data,
    input  logic                 res_pop
);

    localparam int LIW  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int JW   = 6;
    localparam int NG   = (LANES + LANE_GROUP - 1) / LANE_GROUP;
    localparam int CRW  = $clog2(OQ_DEPTH + 1);
    localparam int HW   = $bits(job_head_t);

    job_head_t                  head;
    logic signed [SAMPLE_W-1:0] win      [LANES];
    logic signed [COEF_W-1:0]   coef_reg [LANES];
    logic [LANE_IDX_W-1:0]      issued_reg, issued_next;
    logic [CRW-1:0]             reserved_reg, reserved_next;

    logic [LANE_IDX_W-1:0]      d_cur;
    logic [TAP_CNT_W-1:0]       pad;
    logic                       is_filter, credit_ok, issue, last_res, coef_wr;
    logic signed [JW-1:0]       lane_j   [LANES];
    logic signed [SAMPLE_W-1:0] lane_op  [LANES];
    logic signed [PROD_W-1:0]   prod_next[LANES];
    res_flags_t                 s0_flags;

    logic signed [PROD_W-1:0]   prod_reg [LANES];
    logic                       s1_valid_reg;
    res_flags_t                 s1_flags_reg;
    logic signed [ACC_W-1:0]    grp_next [NG];
    logic signed [ACC_W-1:0]    grp_reg  [NG];
    logic                       s2_valid_reg;
    res_flags_t                 s2_flags_reg;

    logic signed [ACC_W-1:0]    total, shifted;

    always_comb
    begin
        head = job_head_t'(job_data[JOB_W-1 -: HW]);
        for (int i = 0; i < LANES; i++)
        begin
            win[i] = job_data[i*SAMPLE_W +: SAMPLE_W];
        end
    end

    // Results of one job run from the farthest pending column down to the newest.
    assign is_filter = (head.kind == JOB_FILTER);
    assign d_cur     = head.d_first - issued_reg;
    assign last_res  = !head.row_last || (d_cur == '0);
    assign credit_ok = (reserved_reg < CRW'(OQ_DEPTH));
    assign issue     = !job_empty && is_filter && credit_ok;
    assign coef_wr   = !job_empty && !is_filter;
    assign job_pop   = coef_wr || (issue && last_res);
    assign pad       = taps >> 1;

    assign s0_flags.row_end  = head.row_last && (d_cur == '0);
    assign s0_flags.run_last = last_res;

    always_comb
    begin
        issued_next = issued_reg;
        if (issue)
        begin
            issued_next = last_res ? '0 : issued_reg + 1'b1;
        end
        reserved_next = reserved_reg;
        if (issue && !res_pop)
        begin
            reserved_next = reserved_reg + 1'b1;
        end
        else if (res_pop && !issue)
        begin
            reserved_next = reserved_reg - 1'b1;
        end
    end

    // Lane t multiplies coefficient t by the sample at window distance j.
    always_comb
    begin
        for (int t = 0; t < LANES; t++)
        begin
            lane_j[t] = $signed(JW'(d_cur)) + $signed(JW'(pad)) - $signed(JW'(t));
            if ((TAP_CNT_W'(t) < taps) && !lane_j[t][JW-1] &&
                (lane_j[t] < $signed(JW'(LANES))))
            begin
                lane_op[t] = win[lane_j[t][LIW-1:0]];
            end
            else
            begin
                lane_op[t] = '0;
            end
            prod_next[t] = coef_reg[t] * lane_op[t];
        end
    end

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = (g == 0) ? ROUND_BIAS : '0;
            for (int i = 0; i < LANE_GROUP; i++)
            begin
                if (g * LANE_GROUP + i < LANES)
                begin
                    grp_next[g] = grp_next[g] + ACC_W'(prod_reg[g*LANE_GROUP+i]);
                end
            end
        end
    end

    always_comb
    begin
        total = '0;
        for (int g = 0; g < NG; g++)
        begin
            total = total + grp_reg[g];
        end
        shifted = total >>> FRAC_BITS;
        if (shifted > OUT_MAX)
        begin
            res_data.filtered = OUT_W'(OUT_MAX);
        end
        else if (shifted < OUT_MIN)
        begin
            res_data.filtered = OUT_W'(OUT_MIN);
        end
        else
        begin
            res_data.filtered = OUT_W'(shifted);
        end
        res_data.row_end  = s2_flags_reg.row_end;
        res_data.run_last = s2_flags_reg.run_last;
    end

    assign res_push = s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issued_reg   <= '0;
            reserved_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int t = 0; t < LANES; t++)
            begin
                coef_reg[t] <= '0;
            end
        end
        else
        begin
            issued_reg   <= issued_next;
            reserved_reg <= reserved_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            if (coef_wr && ({1'b0, head.tap_index} < (TAP_IDX_W + 1)'(LANES)))
            begin
                coef_reg[head.tap_index[LIW-1:0]] <= head.tap_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int t = 0; t < LANES; t++)
        begin
            prod_reg[t] <= prod_next[t];
        end
        s1_flags_reg <= s0_flags;
        for (int g = 0; g < NG; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
        s2_flags_reg <= s1_flags_reg;
    end

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        reserved_reg <= CRW'(OQ_DEPTH))
        else $error("reserved result slots exceed the result queue depth");

    a_inflight_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (reserved_reg != '0))
        else $error("a result in the pipeline holds no reserved slot");

    a_partial_job: assert property (@(posedge clk) disable iff (!rst_n)
        (issued_reg != '0) |-> (!job_empty && is_filter && head.row_last))
        else $error("partially issued job is not a row flush at the queue head");

endmodule

>>> src/row_fir_zero_padded_top.sv
// Top level of the row-wise zero-padded FIR filter.
//
// The block filters each row of a raster-ordered image with a correlation of up
// to MAX_TAPS taps (capped at 16 coefficient slots); every row is zero-padded on
// its own. An item either loads one Q2.14 coefficient or brings one signed
// 16-bit sample. A sample yields the output column it completes, and the last
// sample of a row flushes the remaining columns of that row. Items are taken
// one per clock cycle while the job queue is not full: the front end
// classifies each item, shifts the sample window and places a job in a
// four-entry job queue, while the back end turns each job into results at
// one per cycle, when result slots are free, through a three-stage multiply
// and adder-tree pipeline feeding an eight-entry result queue. A row-end
// flush yields up to eight results, so a run of short rows can fill the job
// queue and raise full. The first result of a sample passes the job queue,
// the pipeline registers and the result queue before it reaches the result
// ports. Coefficient loads travel through the job queue, so they apply in
// order with samples. Configuration writes are meant for idle periods only.
module row_fir_zero_padded_top
    import rfzp_pkg::*;
#(
    parameter int MAX_TAPS = 16,
    parameter int MAX_ROW  = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    input  in_item_t              item,
    output logic                  full,
    output logic                  empty,
    input  logic                  pop,
    output out_item_t             result
);

    // Number of multiply lanes; coefficient slots beyond this are never used.
    localparam int LANES = (MAX_TAPS < COEF_SLOTS) ? MAX_TAPS : COEF_SLOTS;
    localparam int JOB_W = $bits(job_head_t) + LANES * SAMPLE_W;
    localparam int RES_W = $bits(out_item_t);

    logic                 job_push, job_pop, job_full, job_empty;
    logic [JOB_W-1:0]     job_in, job_out;
    logic [TAP_CNT_W-1:0] taps;
    logic                 res_push, res_full, res_pop;
    out_item_t            res_data;
    logic [RES_W-1:0]     res_out;

    assign full    = job_full;
    assign res_pop = pop && !empty;
    assign result  = out_item_t'(res_out);

    // The front end accepts every transfer and decides whether it needs a job.
    rfzp_front #(
        .LANES   (LANES),
        .MAX_ROW (MAX_ROW),
        .JOB_W   (JOB_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (item),
        .job_full  (job_full),
        .job_push  (job_push),
        .job_data  (job_in),
        .taps      (taps)
    );

    rfzp_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JQ_DEPTH)
    ) u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .full    (job_full),
        .empty   (job_empty)
    );

    // The back end reserves a result slot before it issues, so it never
    // overruns the result queue.
    rfzp_back #(
        .LANES (LANES),
        .JOB_W (JOB_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .taps      (taps),
        .job_empty (job_empty),
        .job_data  (job_out),
        .job_pop   (job_pop),
        .res_push  (res_push),
        .res_data  (res_data),
        .res_pop   (res_pop)
    );

    rfzp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OQ_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .rd_en   (pop),
        .rd_data (res_out),
        .full    (res_full),
        .empty   (empty)
    );

    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written into a full result queue");

endmodule

>>> tb/rfzp_checker.sv
// Checker for the row-wise zero-padded FIR filter: predicts every result and compares.
`timescale 1ns / 100ps

module rfzp_checker
    import rfzp_pkg::*;
#(
    parameter int MAX_TAPS = 16,
    parameter int MAX_ROW  = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    input  in_item_t              item,
    input  logic                  full,
    input  logic                  empty,
    input  logic                  pop,
    input  out_item_t             result,
    output int                    mismatches,
    output int                    outstanding
);

    logic [TAP_CNT_W-1:0]     tap_reg;
    logic [ROW_LEN_W-1:0]     row_reg;
    logic signed [COEF_W-1:0] coef_mem [COEF_SLOTS];
    logic signed [SAMPLE_W-1:0] window [16];
    int                       col_pos;
    int                       error_total;
    out_item_t                pixel_queue [$];

    function automatic int taps_now();
        int k;
        k = tap_reg;
        if (k < 1) k = 1;
        if (k > MAX_TAPS) k = MAX_TAPS;
        if (k > COEF_SLOTS) k = COEF_SLOTS;
        return k;
    endfunction

    function automatic int row_now();
        int m;
        m = row_reg;
        if (m < 1) m = 1;
        if (m > MAX_ROW) m = MAX_ROW;
        return m;
    endfunction

    // Output of column c while the newest sample sits at column p.
    function automatic logic signed [OUT_W-1:0] column_value(int c, int p, int k);
        longint acc;
        longint scaled;
        int     pad;
        int     src;
        int     age;
        acc = 0;
        pad = k / 2;
        for (int t = 0; t < k; t++)
        begin
            src = c - pad + t;
            age = p - src;
            if (src >= 0 && age >= 0 && age < 16)
                acc += longint'(coef_mem[t]) * longint'(window[age]);
        end
        scaled = (acc + 8192) >>> FRAC_BITS;
        if (scaled > 64'sd8388607) scaled = 64'sd8388607;
        if (scaled < -64'sd8388608) scaled = -64'sd8388608;
        return scaled[OUT_W-1:0];
    endfunction

    task automatic take_item(input in_item_t it);
        int        m;
        int        k;
        int        ahead;
        int        p;
        int        first;
        int        last;
        int        n;
        bit        row_done;
        out_item_t px;
        if (it.command == CMD_COEF)
        begin
            coef_mem[it.tap_index] = it.tap_value;
            return;
        end
        m = row_now();
        k = taps_now();
        ahead = k - 1 - k / 2;
        if (col_pos >= m) col_pos = 0;
        if (col_pos == 0)
            for (int i = 0; i < 16; i++) window[i] = '0;
        for (int i = 15; i > 0; i--) window[i] = window[i-1];
        window[0] = it.sample;
        p = col_pos;
        row_done = (col_pos == m - 1);
        first = (p - ahead < 0) ? 0 : p - ahead;
        last = row_done ? m - 1 : p - ahead;
        n = 0;
        for (int c = first; c <= last && n < 8; c++)
        begin
            px.filtered = column_value(c, p, k);
            px.row_end = row_done && (c == m - 1);
            px.run_last = 1'b0;
            pixel_queue.insert(pixel_queue.size(), px);
            n++;
        end
        if (n > 0) pixel_queue[pixel_queue.size()-1].run_last = 1'b1;
        col_pos = row_done ? 0 : col_pos + 1;
    endtask

    task automatic check_result();
        out_item_t want;
        if (pixel_queue.size() == 0)
        begin
            $error("unexpected result: filtered %0d row_end %0b run_last %0b",
                   result.filtered, result.row_end, result.run_last);
            error_total++;
            return;
        end
        want = pixel_queue.pop_front();
        if (result.filtered !== want.filtered)
        begin
            $error("filtered: expected %0d, got %0d", want.filtered, result.filtered);
            error_total++;
        end
        if (result.row_end !== want.row_end)
        begin
            $error("row_end: expected %0b, got %0b", want.row_end, result.row_end);
            error_total++;
        end
        if (result.run_last !== want.run_last)
        begin
            $error("run_last: expected %0b, got %0b", want.run_last, result.run_last);
            error_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg = TAP_CNT_W'(1);
            row_reg = ROW_LEN_W'(4096);
            col_pos = 0;
            error_total = 0;
            for (int i = 0; i < COEF_SLOTS; i++) coef_mem[i] = '0;
            for (int i = 0; i < 16; i++) window[i] = '0;
            pixel_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_TAP_COUNT:  tap_reg = cfg_data[TAP_CNT_W-1:0];
                    CFG_ROW_LENGTH: row_reg = cfg_data[ROW_LEN_W-1:0];
                    default: ;
                endcase
            end
            // A result popped now cannot stem from an item pushed at this edge.
            if (pop && !empty) check_result();
            if (push && !full) take_item(item);
        end
        outstanding <= pixel_queue.size();
        mismatches <= error_total;
    end

endmodule

>>> tb/row_fir_zero_padded_top_tb.sv
// Testbench top for the row-wise zero-padded FIR filter: stimulus, result drain and verdict.
`timescale 1ns / 100ps

module row_fir_zero_padded_top_tb
    import rfzp_pkg::*;
();

    localparam int ITEM_TARGET = 410;
    // Longest stretch without any transfer before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  push;
    in_item_t              item;
    logic                  full;
    logic                  empty;
    logic                  pop = 1'b0;
    out_item_t             result;

    int  mismatches;
    int  outstanding;
    int  items_sent;
    int  quiet_cycles = 0;
    int  pop_stall = 0;
    bit  result_taken;
    // When set, the matching side runs without gaps for the current phase.
    bit  tx_calm;
    bit  rx_calm;

    row_fir_zero_padded_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    rfzp_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .item        (item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // The result side: after each transfer it holds pop low for a random number
    // of cycles, then keeps pop high until the next result is taken. The
    // transfer is recorded at the rising edge and acted on at the falling edge,
    // so pop gets exactly one update per falling edge.
    always @(posedge clk) result_taken <= pop && !empty;

    always @(negedge clk)
    begin
        if (result_taken)
            pop_stall = rx_calm ? 0 : $urandom_range(0, 7);
        if (pop_stall > 0)
        begin
            pop_stall--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    // Watchdog: any transfer on either side restarts the count.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // A 16-bit word that leans toward the two extremes.
    function automatic logic signed [15:0] draw_word();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Tap count, including values that the block has to saturate.
    function automatic logic [TAP_CNT_W-1:0] draw_taps();
        case ($urandom_range(0, 9))
            0:       return TAP_CNT_W'(0);
            1:       return TAP_CNT_W'(31);
            2:       return TAP_CNT_W'(16);
            3:       return TAP_CNT_W'(17);
            default: return TAP_CNT_W'($urandom_range(1, 16));
        endcase
    endfunction

    // Row length: mostly short rows so that row-end flushes are frequent.
    function automatic logic [ROW_LEN_W-1:0] draw_row();
        case ($urandom_range(0, 11))
            0:       return ROW_LEN_W'(0);
            1:       return ROW_LEN_W'(8191);
            2:       return ROW_LEN_W'(4096);
            3:       return ROW_LEN_W'(4097);
            4:       return ROW_LEN_W'($urandom_range(13, 64));
            default: return ROW_LEN_W'($urandom_range(1, 12));
        endcase
    endfunction

    // The unused fields of each item carry random junk, which must be ignored.
    function automatic in_item_t make_sample(logic signed [15:0] value);
        in_item_t it;
        it.command   = CMD_SAMPLE;
        it.sample    = value;
        it.tap_index = TAP_IDX_W'($urandom);
        it.tap_value = COEF_W'($urandom);
        return it;
    endfunction

    function automatic in_item_t make_coef(logic [TAP_IDX_W-1:0] slot,
                                           logic signed [15:0] value);
        in_item_t it;
        it.command   = CMD_COEF;
        it.sample    = SAMPLE_W'($urandom);
        it.tap_index = slot;
        it.tap_value = value;
        return it;
    endfunction

    // One input transfer, after a random gap. The task returns at the rising
    // edge that takes the item; push stays high until the next falling edge,
    // where the next call or a settle decides its new value.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        items_sent++;
    endtask

    // Stop sending and let the block drain. Items that cause no result (a
    // coefficient load, or the first samples of a row) may still be in the
    // pipeline once the last result is out, hence the extra cycles.
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int span;
        int shrink_at;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_TAP_COUNT;
        cfg_data  = '0;
        push      = 1'b0;
        item      = '0;
        tx_calm   = 1'b0;
        rx_calm   = 1'b0;
        items_sent = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Reset settings first: one tap, a 4096-pixel row.
        // The load into slot 15 lies beyond the taps in use and must not count.
        send_item(make_coef(TAP_IDX_W'(0), 16'sh7FFF));
        send_item(make_coef(TAP_IDX_W'(15), 16'sh8000));
        send_item(make_sample(16'sh7FFF));
        send_item(make_sample(16'sh8000));
        send_item(make_sample(16'sh0000));

        // A tap count of 31 saturates to the maximum; the upper data bits are
        // junk. A three-pixel row is shorter than the lookahead, so nothing
        // comes out until its last sample flushes the whole row.
        settle();
        write_reg(CFG_TAP_COUNT, {8'hFF, 5'd31});
        write_reg(CFG_ROW_LENGTH, CFG_DATA_W'(3));
        send_item(make_coef(TAP_IDX_W'(8), 16'sh4000));
        send_item(make_coef(TAP_IDX_W'(1), 16'sh8000));
        send_item(make_sample(-16'sd1));
        send_item(make_sample(16'sd100));
        send_item(make_sample(16'sh8000));

        // Zero in both registers saturates to one tap and one-pixel rows.
        settle();
        write_reg(CFG_TAP_COUNT, CFG_DATA_W'(0));
        write_reg(CFG_ROW_LENGTH, CFG_DATA_W'(0));
        send_item(make_sample(16'sd1234));
        send_item(make_sample(-16'sd5));

        // Oversized row length saturates; then, mid-row, the row is shortened
        // below the current column (next sample opens a new row) and the tap
        // count changes while the window is kept.
        settle();
        write_reg(CFG_TAP_COUNT, CFG_DATA_W'(4));
        write_reg(CFG_ROW_LENGTH, CFG_DATA_W'(8191));
        repeat (6) send_item(make_sample(draw_word()));
        settle();
        write_reg(CFG_ROW_LENGTH, CFG_DATA_W'(2));
        write_reg(CFG_TAP_COUNT, CFG_DATA_W'(5));
        send_item(make_sample(draw_word()));
        send_item(make_sample(draw_word()));

        // Random part: phases of fresh settings, each a stream of samples with
        // coefficient loads mixed in. Some phases run one or both sides without
        // gaps, and some shrink the row and redraw the tap count mid-stream.
        while (items_sent < ITEM_TARGET)
        begin
            settle();
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            write_reg(CFG_TAP_COUNT, {8'($urandom), draw_taps()});
            write_reg(CFG_ROW_LENGTH, draw_row());
            span = $urandom_range(20, 50);
            shrink_at = ($urandom_range(0, 2) == 0) ? $urandom_range(5, span - 5) : -1;
            for (int n = 0; n < span; n++)
            begin
                if (n == shrink_at)
                begin
                    settle();
                    write_reg(CFG_ROW_LENGTH, CFG_DATA_W'($urandom_range(1, 6)));
                    write_reg(CFG_TAP_COUNT, CFG_DATA_W'($urandom_range(1, 16)));
                end
                if ($urandom_range(0, 5) == 0)
                    send_item(make_coef(TAP_IDX_W'($urandom), draw_word()));
                else
                    send_item(make_sample(draw_word()));
            end
        end

        // Drain everything; the settle margin also catches stray late results.
        settle();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
